// ===== sv/m3a_pkg.sv =====
// Shared types, constants and operand schedule for the 3x3 matrix arithmetic unit.
package m3a_pkg;

	localparam int DIM          = 3;
	localparam int CELLS        = DIM * DIM;
	localparam int POS_W        = $clog2(CELLS);
	localparam int DATA_W       = 32;
	localparam int ACC_W        = 98;
	localparam int DEF_FRAC     = 16;
	localparam int DEF_QDEPTH   = 4;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(CELLS - 1);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_MUL = 2'd1,
		OP_DET = 2'd2,
		OP_DOT = 2'd3
	} op_t;

	// one accepted element pair, tagged with its matrix position
	typedef struct packed {
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [POS_W-1:0]  pos;
		op_t               op;
	} item_t;

	// one product term: A[x] * (B[y] or A[y]) [* A[z]], negated if neg
	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
		logic             y_from_b;
		logic             neg;
	} term_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RDX,
		ST_RDY,
		ST_MUL1,
		ST_MULL,
		ST_MULH,
		ST_ACC,
		ST_EMIT
	} back_state_t;

	function automatic logic [POS_W-1:0] n_groups(input op_t op);
		unique case (op) inside
			OP_ADD, OP_MUL: n_groups = POS_W'(CELLS);
			default:        n_groups = POS_W'(1);
		endcase
	endfunction

	function automatic logic [POS_W-1:0] n_terms(input op_t op);
		unique case (op)
			OP_ADD:  n_terms = POS_W'(1);
			OP_MUL:  n_terms = POS_W'(DIM);
			OP_DET:  n_terms = POS_W'(6);
			default: n_terms = POS_W'(CELLS);
		endcase
	endfunction

	function automatic term_t term_of(input op_t op, input logic [POS_W-1:0] grp,
		input logic [POS_W-1:0] k);
		term_t            t;
		logic [POS_W-1:0] row3;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] k3;
		t    = '0;
		row3 = (grp >= POS_W'(6)) ? POS_W'(6) : (grp >= POS_W'(3)) ? POS_W'(3) : '0;
		col  = grp - row3;
		k3   = (k == POS_W'(0)) ? '0 : (k == POS_W'(1)) ? POS_W'(3) : POS_W'(6);
		unique case (op)
			OP_ADD: begin
				t.x = grp;
				t.y = grp;
				t.y_from_b = 1'b1;
			end
			OP_MUL: begin
				t.x = row3 + k;
				t.y = k3 + col;
				t.y_from_b = 1'b1;
			end
			OP_DET: begin
				// cofactor expansion along the first row, six signed triples
				unique case (k)
					POS_W'(0): begin t.x = 4'd0; t.y = 4'd4; t.z = 4'd8; t.neg = 1'b0; end
					POS_W'(1): begin t.x = 4'd0; t.y = 4'd7; t.z = 4'd5; t.neg = 1'b1; end
					POS_W'(2): begin t.x = 4'd1; t.y = 4'd3; t.z = 4'd8; t.neg = 1'b1; end
					POS_W'(3): begin t.x = 4'd1; t.y = 4'd6; t.z = 4'd5; t.neg = 1'b0; end
					POS_W'(4): begin t.x = 4'd2; t.y = 4'd3; t.z = 4'd7; t.neg = 1'b0; end
					default:   begin t.x = 4'd2; t.y = 4'd6; t.z = 4'd4; t.neg = 1'b1; end
				endcase
			end
			default: begin
				t.x = k;
				t.y = k;
				t.y_from_b = 1'b1;
			end
		endcase
		return t;
	endfunction

endpackage

// ===== sv/m3a_fifo.sv =====
// Short item queue between the front and back parts.
module m3a_fifo
	import m3a_pkg::*;
#(
	parameter int DEPTH = DEF_QDEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t head,
	output logic  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/m3a_front.sv =====
// Input side: accept items, tag each with its matrix position and operation.
module m3a_front
	import m3a_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [2*DATA_W-1:0] s_tdata,
	input  logic               cfg_wen,
	input  logic [1:0]         cfg_wdata,
	input  logic               q_full,
	output logic               q_push,
	output item_t              q_item
);

	logic [POS_W-1:0] pos_q;
	op_t              op_q;

	assign s_tready     = !q_full;
	assign q_push       = s_tvalid && !q_full;
	assign q_item.a     = s_tdata[DATA_W-1:0];
	assign q_item.b     = s_tdata[2*DATA_W-1:DATA_W];
	assign q_item.pos   = pos_q;
	assign q_item.op    = op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			op_q  <= OP_MUL;
		end else begin
			if (cfg_wen) begin
				op_q <= op_t'(cfg_wdata);
			end
			if (q_push) begin
				pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
			end
		end
	end

endmodule

// ===== sv/m3a_back.sv =====
// Execution side: matrix stores, shared multiplier, accumulator and result register.
module m3a_back
	import m3a_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC
) (
	input  logic              clk,
	input  logic              arst_n,
	input  item_t             q_head,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,
	output logic              m_tlast
);

	logic [DATA_W-1:0] a_mem [CELLS];
	logic [DATA_W-1:0] b_mem [CELLS];
	logic [DATA_W-1:0] a_rd_q;
	logic [DATA_W-1:0] b_rd_q;

	back_state_t       state_q;
	back_state_t       state_nx;
	op_t               op_q;
	logic [POS_W-1:0]  grp_q;
	logic [POS_W-1:0]  k_q;
	logic [DATA_W-1:0] opx_q;
	logic [DATA_W-1:0] opyb_q;
	logic [DATA_W-1:0] opz_q;
	logic [63:0]       prod_q;
	logic [64:0]       ml_q;
	logic [63:0]       mh_q;
	logic [ACC_W-1:0]  acc_q;
	logic              m_valid_q;
	logic [DATA_W-1:0] m_data_q;
	logic              m_last_q;

	term_t             term;
	logic              last_term;
	logic              last_grp;
	logic              out_load;
	logic [POS_W-1:0]  rd_a;
	logic [POS_W-1:0]  rd_b;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;
	logic [ACC_W-1:0]  term_val;
	logic signed [ACC_W-1:0] shifted;
	logic [DATA_W-1:0] sat_val;
	logic              fits;

	assign term      = term_of(op_q, grp_q, k_q);
	assign last_term = (k_q == n_terms(op_q) - 1'b1);
	assign last_grp  = (grp_q == n_groups(op_q) - 1'b1);

	// stores: written while loading, read one address per cycle with registered data
	always_ff @(posedge clk) begin
		if (q_pop) begin
			a_mem[q_head.pos] <= q_head.a;
			b_mem[q_head.pos] <= q_head.b;
		end
		a_rd_q <= a_mem[rd_a];
		b_rd_q <= b_mem[rd_b];
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD: if (!q_empty && q_head.pos == LAST_POS) state_nx = ST_RDX;
			ST_RDX:  state_nx = ST_RDY;
			ST_RDY:  state_nx = ST_MUL1;
			ST_MUL1: state_nx = (op_q == OP_DET) ? ST_MULL : ST_ACC;
			ST_MULL: state_nx = ST_MULH;
			ST_MULH: state_nx = ST_ACC;
			ST_ACC:  state_nx = last_term ? ST_EMIT : ST_RDX;
			ST_EMIT: begin
				if (out_load) state_nx = last_grp ? ST_LOAD : ST_RDX;
			end
			default: state_nx = ST_LOAD;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop    = 1'b0;
		rd_a     = term.x;
		rd_b     = term.y;
		out_load = 1'b0;
		unique case (state_q)
			ST_LOAD: q_pop = !q_empty;
			ST_RDY:  rd_a = term.y;
			ST_MUL1: rd_a = term.z;
			ST_EMIT: out_load = !m_valid_q || m_tready;
			default: begin
				rd_a = term.x;
			end
		endcase
	end

	// one shared signed 33x33 multiplier
	always_comb begin
		mul_a = 33'(signed'(opx_q));
		mul_b = term.y_from_b ? 33'(signed'(opyb_q)) : 33'(signed'(a_rd_q));
		case (state_q)
			ST_MULL: begin
				mul_a = signed'({1'b0, prod_q[31:0]});
				mul_b = 33'(signed'(a_rd_q));
			end
			ST_MULH: begin
				mul_a = 33'(signed'(prod_q[63:32]));
				mul_b = 33'(signed'(opz_q));
			end
			default: begin
				mul_a = 33'(signed'(opx_q));
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// triple product recombined from its two halves
	always_comb begin
		if (op_q == OP_DET) begin
			term_val = ACC_W'(signed'({mh_q, 32'd0})) + ACC_W'(signed'(ml_q));
		end else begin
			term_val = ACC_W'(signed'(prod_q));
		end
	end

	// floor shift then saturate to 32 bits
	always_comb begin
		unique case (op_q)
			OP_ADD:  shifted = signed'(acc_q);
			OP_DET:  shifted = signed'(acc_q) >>> (2 * FRAC_BITS);
			default: shifted = signed'(acc_q) >>> FRAC_BITS;
		endcase
		fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);
		sat_val = fits ? shifted[DATA_W-1:0]
		               : (shifted[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_RDY: begin
				opx_q  <= a_rd_q;
				opyb_q <= b_rd_q;
			end
			ST_MUL1: begin
				if (op_q == OP_ADD) begin
					prod_q <= 64'(signed'(opx_q)) + 64'(signed'(opyb_q));
				end else begin
					prod_q <= mul_p[63:0];
				end
			end
			ST_MULL: begin
				opz_q <= a_rd_q;
				ml_q  <= mul_p[64:0];
			end
			ST_MULH: mh_q <= mul_p[63:0];
			default: begin
				opx_q <= opx_q;
			end
		endcase
		if (out_load) begin
			m_data_q <= sat_val;
			m_last_q <= last_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			op_q      <= OP_MUL;
			grp_q     <= '0;
			k_q       <= '0;
			acc_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						op_q  <= q_head.op;
						grp_q <= '0;
						k_q   <= '0;
						acc_q <= '0;
					end
				end
				ST_ACC: begin
					acc_q <= term.neg ? acc_q - term_val : acc_q + term_val;
					if (!last_term) k_q <= k_q + 1'b1;
				end
				ST_EMIT: begin
					if (out_load && !last_grp) begin
						grp_q <= grp_q + 1'b1;
						k_q   <= '0;
						acc_q <= '0;
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== sv/matrix3x3_arith_unit_top.sv =====
// Top level of the 3x3 matrix arithmetic unit: front, item queue and back.
//
// The unit takes nine items, each one element of matrix A and the element of
// matrix B at the same place, in row-major order, all signed Q16.16 (the
// fraction width is FRAC_BITS). After the ninth item it runs the operation
// held in the configuration register at that moment: 0 add and 1 multiply
// give nine elements in row-major order, 2 determinant of A and 3 elementwise
// inner product give one scalar; m_tlast marks the final result of a run.
// Results are floored to the fraction width and saturated to 32 bits. The
// front accepts one item per cycle while the queue has room; the back loads
// one item per cycle while the queue is not empty and then computes on one
// shared 33x33 multiplier, with one read port on each store: each term is
// read from the stores, formed (a product, or a sum for add) and added into
// the accumulator, and each result is held in a register until taken.
module matrix3x3_arith_unit_top
	import m3a_pkg::*;
#(
	parameter int FRAC_BITS   = DEF_FRAC,
	parameter int QUEUE_DEPTH = DEF_QDEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2*DATA_W-1:0] s_tdata,   // [31:0] a_value, [63:32] b_value
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [DATA_W-1:0]   m_tdata,   // [31:0] value
	output logic                m_tlast,
	input  logic                cfg_wen,
	input  logic [1:0]          cfg_wdata  // operation
);

	item_t q_in;
	item_t q_head;
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;

	// tag items with position and operation
	m3a_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_in)
	);

	// decouple input acceptance from the compute sequence
	m3a_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// load the stores, compute and hold each result until taken
	m3a_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

// ===== tb/testbench.sv =====
// Testbench for matrix3x3_arith_unit_top: directed and random matrix runs checked against a predictor.
`timescale 1ns / 100ps

module testbench;
	import m3a_pkg::*;

	localparam int FRAC           = DEF_FRAC;
	localparam int SETTLE_CYCLES  = 200;   // longer than one full multiply run
	localparam int WATCHDOG_LIMIT = 4000;  // cycles in a row with no handshake

	localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN  = 32'h8000_0000;
	localparam logic [31:0] Q_ONE  = 32'h0001_0000;
	localparam logic [31:0] Q_NEG1 = 32'hFFFF_FFFF;
	localparam logic [31:0] Q_ZERO = 32'h0000_0000;

	localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
	localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
	} matrix_result_t;

	// Bus signals; every input starts at a known value.
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [63:0]       s_tdata   = '0;   // [31:0] a_value, [63:32] b_value
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [31:0]       m_tdata;          // [31:0] value
	logic              m_tlast;
	logic              cfg_wen   = 1'b0;
	logic [1:0]        cfg_wdata = OP_MUL;

	// Predictor state: the two matrices, the next load position, the operation.
	logic signed [31:0] a_cells [CELLS];
	logic signed [31:0] b_cells [CELLS];
	int                 load_pos   = 0;
	op_t                current_op = OP_MUL;

	matrix_result_t pending_results [$];
	int             fail_count   = 0;
	int             quiet_cycles = 0;
	int             ready_hold   = 0;
	bit             steady       = 1'b0;  // when set, neither side idles

	matrix3x3_arith_unit_top #(
		.FRAC_BITS(FRAC)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Floor the exact sum by sh bits, then clamp to signed 32 bits.
	function automatic logic [31:0] floor_saturate(input logic signed [127:0] acc,
		input int sh);
		logic signed [127:0] shifted;
		shifted = acc >>> sh;
		if (shifted > SAT_HI)
			return Q_MAX;
		if (shifted < SAT_LO)
			return Q_MIN;
		return shifted[31:0];
	endfunction

	// Mostly small values so that results stay in range; some full-range and extremes.
	function automatic logic [31:0] random_element();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			unique case ($urandom_range(0, 4))
				0:       return Q_MAX;
				1:       return Q_MIN;
				2:       return Q_ZERO;
				3:       return Q_NEG1;
				default: return Q_ONE;
			endcase
		end
		if (r < 4)
			return $urandom;
		return 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
	endfunction

	// Load one accepted element pair; after the ninth, queue the run's results.
	task automatic load_and_predict(input logic [31:0] a_val, input logic [31:0] b_val);
		logic signed [127:0] acc;
		a_cells[load_pos] = a_val;
		b_cells[load_pos] = b_val;
		load_pos++;
		if (load_pos < CELLS)
			return;
		load_pos = 0;
		unique case (current_op)
			OP_ADD: begin
				for (int i = 0; i < CELLS; i++) begin
					acc = a_cells[i] + b_cells[i];
					pending_results.push_back('{floor_saturate(acc, 0), i == CELLS - 1});
				end
			end
			OP_MUL: begin
				for (int i = 0; i < DIM; i++)
					for (int j = 0; j < DIM; j++) begin
						acc = '0;
						for (int k = 0; k < DIM; k++)
							acc = acc + a_cells[i*DIM+k] * b_cells[k*DIM+j];
						pending_results.push_back('{floor_saturate(acc, FRAC),
							(i == DIM - 1) && (j == DIM - 1)});
					end
			end
			OP_DET: begin
				// cofactor expansion of A along its first row; B plays no part
				acc = a_cells[0] * (a_cells[4] * a_cells[8] - a_cells[7] * a_cells[5])
				    - a_cells[1] * (a_cells[3] * a_cells[8] - a_cells[6] * a_cells[5])
				    + a_cells[2] * (a_cells[3] * a_cells[7] - a_cells[6] * a_cells[4]);
				pending_results.push_back('{floor_saturate(acc, 2 * FRAC), 1'b1});
			end
			default: begin
				acc = '0;
				for (int i = 0; i < CELLS; i++)
					acc = acc + a_cells[i] * b_cells[i];
				pending_results.push_back('{floor_saturate(acc, FRAC), 1'b1});
			end
		endcase
	endtask

	// Offer one item after a random gap (none while steady) and hold it until accepted. Leave tvalid
	// high afterwards so that a back-to-back item needs no second assignment.
	task automatic send_item(input logic [31:0] a_val, input logic [31:0] b_val);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b_val, a_val};
		do @(posedge clk); while (!s_tready);
		load_and_predict(a_val, b_val);
	endtask

	// Drop tvalid, drain every expected result, then let the back end finish
	// any loads that produce no result.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_operation(input op_t op);
		quiesce();
		cfg_wen   <= 1'b1;
		cfg_wdata <= op;
		@(posedge clk);
		cfg_wen    <= 1'b0;
		current_op  = op;
	endtask

	// Multiply straight out of reset, with both saturation directions.
	task automatic test_reset_multiply();
		logic [31:0] a_vals [CELLS];
		logic [31:0] b_vals [CELLS];
		a_vals = '{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_ONE, Q_NEG1, Q_ZERO};
		b_vals = '{Q_MAX, Q_MIN, Q_ONE, Q_MAX, Q_MIN, Q_NEG1, Q_ONE, Q_MAX, Q_MIN};
		for (int i = 0; i < CELLS; i++)
			send_item(a_vals[i], b_vals[i]);
	endtask

	// Add at the extremes, plus carries across the fraction boundary.
	task automatic test_add_extremes();
		logic [31:0] a_vals [CELLS];
		logic [31:0] b_vals [CELLS];
		set_operation(OP_ADD);
		a_vals = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_NEG1, Q_ZERO, Q_ONE,
			32'h0000_8000, 32'h1234_5678};
		b_vals = '{Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_ONE, Q_ZERO, Q_NEG1,
			32'h0000_8000, 32'hEDCB_A988};
		for (int i = 0; i < CELLS; i++)
			send_item(a_vals[i], b_vals[i]);
	endtask

	// Start a run under add, switch to determinant halfway: the value held at
	// the ninth item decides. B is random and must not matter.
	task automatic test_det_midrun_switch();
		logic [31:0] a_vals [CELLS];
		a_vals = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_NEG1, Q_ONE, Q_MAX, Q_MIN};
		for (int i = 0; i < 4; i++)
			send_item(a_vals[i], $urandom);
		set_operation(OP_DET);
		for (int i = 4; i < CELLS; i++)
			send_item(a_vals[i], $urandom);
	endtask

	// Inner product with a negative overflow and small negative fractions.
	task automatic test_dot_extremes();
		logic [31:0] a_vals [CELLS];
		logic [31:0] b_vals [CELLS];
		set_operation(OP_DOT);
		a_vals = '{Q_MAX, Q_MAX, Q_MIN, Q_NEG1, Q_ONE, Q_ZERO, Q_MAX, Q_MIN, Q_NEG1};
		b_vals = '{Q_MIN, Q_MIN, Q_MAX, Q_ONE, Q_NEG1, Q_MAX, Q_MIN, Q_MAX, Q_MAX};
		for (int i = 0; i < CELLS; i++)
			send_item(a_vals[i], b_vals[i]);
	endtask

	// Random runs, each operation in turn and then random ones, occasional switches
	// partway through a run, and stretches where neither side idles.
	task automatic test_random_runs();
		int  split;
		bit  switch_midrun;
		for (int run = 0; run < 9; run++) begin
			if (run < 4)
				set_operation(op_t'(run));
			else if ($urandom_range(0, 1) == 1)
				set_operation(op_t'($urandom_range(0, 3)));
			steady        = ($urandom_range(0, 3) == 0);
			switch_midrun = ($urandom_range(0, 4) == 0);
			split         = $urandom_range(1, CELLS - 1);
			for (int i = 0; i < CELLS; i++) begin
				if (switch_midrun && i == split)
					set_operation(op_t'($urandom_range(0, 3)));
				send_item(random_element(), random_element());
			end
		end
		steady = 1'b0;
	endtask

	// Receiver: accept by default, stall now and then for a random stretch.
	always @(posedge clk) begin
		if (steady) begin
			m_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			m_tready   <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 99) < 30)
				ready_hold <= pick_gap();
		end
	end

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		matrix_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: value %h last %b", m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.value) begin
					$error("value: expected %h, got %h", want.value, m_tdata);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %b, got %b", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run if no item moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_multiply();
		test_add_extremes();
		test_det_midrun_switch();
		test_dot_extremes();
		test_random_runs();
		quiesce();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
